FILE: src/bmpb_pkg.sv
// Shared types, constants and status-byte helpers for the BLE MIDI packet builder.
// Used by every module of the block; has no dependencies of its own.
package bmpb_pkg;

  // Packet size ceiling applied on top of the programmed limit.
  localparam int COUNT_LIMIT = 512;

  // Byte counter width, and the wider width of counter plus appended bytes.
  localparam int CNT_W = 10;
  localparam int SUM_W = 11;
  localparam logic [SUM_W-1:0] COUNT_LIMIT_V = SUM_W'(COUNT_LIMIT);

  // One item appends at most this many bytes.
  localparam int MAX_BYTES = 5;
  localparam int NB_W      = $clog2(MAX_BYTES + 1);

  // Depth of the queue between front and back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration register indexes.
  localparam logic [1:0] REG_MAX_PACKET_BYTES    = 2'd0;
  localparam logic [1:0] REG_RUNNING_STATUS_ON   = 2'd1;
  localparam logic [1:0] REG_NOTE_OFF_TO_NOTE_ON = 2'd2;
  localparam logic [CNT_W-1:0] MAX_PACKET_BYTES_RST = CNT_W'(20);

  // Input item kinds.
  localparam logic [2:0] KIND_MSG       = 3'd0;
  localparam logic [2:0] KIND_SX_START  = 3'd1;
  localparam logic [2:0] KIND_SX_DATA   = 3'd2;
  localparam logic [2:0] KIND_SX_END    = 3'd3;
  localparam logic [2:0] KIND_PKT_RESET = 3'd4;

  // Result codes.
  localparam logic [2:0] RC_OK           = 3'd0;
  localparam logic [2:0] RC_PACKET_FULL  = 3'd1;
  localparam logic [2:0] RC_BAD_STATUS   = 3'd2;
  localparam logic [2:0] RC_BAD_DATA     = 3'd3;
  localparam logic [2:0] RC_IN_SYSEX     = 3'd4;
  localparam logic [2:0] RC_NOT_IN_SYSEX = 3'd5;

  // Status byte values.
  localparam logic [7:0] ST_SYSEX_START = 8'hF0;
  localparam logic [7:0] ST_SYSEX_END   = 8'hF7;
  localparam logic [3:0] HI_NOTE_OFF    = 4'h8;
  localparam logic [3:0] HI_NOTE_ON     = 4'h9;

  // What the front hands to the back for one input item. A count of zero
  // means a single result without a byte, carrying the code.
  typedef struct packed {
    logic [NB_W-1:0]                 cnt;
    logic [2:0]                      code;
    logic [MAX_BYTES-1:0][7:0]       bytes;
  } rec_t;

  // Queue status seen by the front.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Total message length for a status byte; zero for an unknown status.
  function automatic logic [1:0] msg_size(input logic [7:0] s);
    logic [1:0] sz;
    sz = 2'd0;
    case (s[7:4])
      4'h8, 4'h9, 4'hA, 4'hB, 4'hE: sz = 2'd3;
      4'hC, 4'hD:                   sz = 2'd2;
      4'hF: begin
        case (s)
          8'hF8, 8'hFA, 8'hFB, 8'hFC, 8'hFE, 8'hFF, 8'hF6: sz = 2'd1;
          8'hF1, 8'hF3:                                     sz = 2'd2;
          8'hF2:                                            sz = 2'd3;
          default:                                          sz = 2'd0;
        endcase
      end
      default: sz = 2'd0;
    endcase
    return sz;
  endfunction

  function automatic logic is_realtime(input logic [7:0] s);
    return (s == 8'hF8) || (s == 8'hFA) || (s == 8'hFB) || (s == 8'hFC) ||
           (s == 8'hFE) || (s == 8'hFF);
  endfunction

  function automatic logic is_channel(input logic [7:0] s);
    return (s[7:4] >= 4'h8) && (s[7:4] <= 4'hE);
  endfunction

endpackage

FILE: src/ble_midi_packet_builder_core.sv
// BLE MIDI packet builder: each input item turns into its appended packet bytes or into
// one status result without a byte. Each accepted input beat yields one output beat per
// appended byte (one to five), or a single beat for an error, a packet reset or an
// ignored kind; the last beat of an item carries tlast. The input side classifies an
// item in the cycle it is accepted and takes a new beat every cycle while its
// two-entry record queue has room. The output side sends one result per cycle from
// its output register while out_tready is high, so the results of an item leave it
// one after another (one to five). Sustained throughput is therefore one result per
// cycle when out_tready stays high. Configuration registers are written through cfg_we;
// the user must do so only while no item is in flight; the block does not enforce it.
// Depends on bmpb_pkg, bmpb_front, bmpb_queue and bmpb_back.
module ble_midi_packet_builder_core import bmpb_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [CNT_W-1:0]  cfg_wdata,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [39:0]       in_tdata,   // status_in[7:0], data1[15:8], data2[23:16], timestamp[36:24]
  input  logic [2:0]        in_tuser,   // kind[2:0]
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,  // out_byte[7:0]
  output logic [3:0]        out_tuser,  // has_byte[0], result_code[3:1]
  output logic              out_tlast   // last
);

  rec_t       wr_rec;
  rec_t       head;
  q_stat_t    q_stat;
  logic       push;
  logic       pop;
  logic       has_byte;
  logic [2:0] result_code;

  bmpb_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .kind      (in_tuser),
    .status_in (in_tdata[7:0]),
    .data1     (in_tdata[15:8]),
    .data2     (in_tdata[23:16]),
    .timestamp (in_tdata[36:24]),
    .q_stat    (q_stat),
    .push      (push),
    .rec       (wr_rec)
  );

  bmpb_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_rec (wr_rec),
    .pop    (pop),
    .rd_rec (head),
    .stat   (q_stat)
  );

  bmpb_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head        (head),
    .head_valid  (!q_stat.empty),
    .pop         (pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_byte    (out_tdata),
    .has_byte    (has_byte),
    .result_code (result_code),
    .last        (out_tlast)
  );

  assign out_tuser = {result_code, has_byte};

endmodule

FILE: src/bmpb_front.sv
// Front end: configuration registers, packet state and classification of each input beat
// into the bytes it appends or one result without a byte. Depends on bmpb_pkg.
module bmpb_front import bmpb_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [CNT_W-1:0]  cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        kind,
  input  logic [7:0]        status_in,
  input  logic [7:0]        data1,
  input  logic [7:0]        data2,
  input  logic [12:0]       timestamp,
  input  q_stat_t           q_stat,
  output logic              push,
  output rec_t              rec
);

  logic [CNT_W-1:0] max_packet_bytes_r;
  logic             running_status_on_r;
  logic             note_off_to_note_on_r;

  logic [CNT_W-1:0] byte_count_r,     byte_count_nxt;
  logic [7:0]       last_status_r,    last_status_nxt;
  logic [12:0]      last_timestamp_r, last_timestamp_nxt;
  logic             running_active_r, running_active_nxt;
  logic             timestamp_due_r,  timestamp_due_nxt;
  logic             sysex_open_r,     sysex_open_nxt;

  logic [SUM_W-1:0] limit;

  assign in_ready = !q_stat.full;
  assign push     = in_valid && !q_stat.full;
  assign limit    = ({1'b0, max_packet_bytes_r} > COUNT_LIMIT_V) ? COUNT_LIMIT_V
                                                                 : {1'b0, max_packet_bytes_r};

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_packet_bytes_r    <= MAX_PACKET_BYTES_RST;
      running_status_on_r   <= 1'b0;
      note_off_to_note_on_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAX_PACKET_BYTES:    max_packet_bytes_r    <= cfg_wdata;
        REG_RUNNING_STATUS_ON:   running_status_on_r   <= cfg_wdata[0];
        REG_NOTE_OFF_TO_NOTE_ON: note_off_to_note_on_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Classify the beat, build its bytes and work out the state it leaves.
  always_comb begin
    logic [NB_W-1:0]           n;
    logic [MAX_BYTES-1:0][7:0] bb;
    logic                      app;
    logic                      msg_upd;
    logic                      sx_start;
    logic                      sx_end;
    logic                      hdr;
    logic [7:0]                hbyte;
    logic [7:0]                sbyte;
    logic [1:0]                sz;
    logic [7:0]                prev;
    logic                      due;
    logic                      run;
    logic                      chan;
    logic                      skip;
    logic [7:0]                st_m;
    logic [7:0]                d2_m;
    logic [SUM_W-1:0]          sum;

    n        = '0;
    bb       = '0;
    app      = 1'b0;
    msg_upd  = 1'b0;
    sx_start = 1'b0;
    sx_end   = 1'b0;
    hdr      = (byte_count_r == '0);
    hbyte    = {2'b10, timestamp[12:7]};
    sbyte    = {1'b1, timestamp[6:0]};
    sz       = msg_size(status_in);
    prev     = last_status_r;
    due      = timestamp_due_r;
    run      = running_active_r;
    chan     = is_channel(status_in);
    skip     = 1'b0;
    st_m     = status_in;
    d2_m     = data2;

    rec.cnt   = '0;
    rec.code  = RC_OK;
    rec.bytes = '0;

    byte_count_nxt     = byte_count_r;
    last_status_nxt    = last_status_r;
    last_timestamp_nxt = last_timestamp_r;
    running_active_nxt = running_active_r;
    timestamp_due_nxt  = timestamp_due_r;
    sysex_open_nxt     = sysex_open_r;

    case (kind)
      KIND_MSG: begin
        if (sysex_open_r) begin
          // Only realtime messages may interrupt a sysex.
          if (!is_realtime(status_in)) begin
            rec.code = RC_BAD_STATUS;
          end else begin
            if (hdr) begin
              bb[n] = hbyte;
              n     = n + 1'b1;
            end
            bb[n] = sbyte;
            n     = n + 1'b1;
            bb[n] = status_in;
            n     = n + 1'b1;
            app   = 1'b1;
          end
        end else if (sz == 2'd0) begin
          rec.code = RC_BAD_STATUS;
        end else if ((sz >= 2'd2) && data1[7]) begin
          rec.code = RC_BAD_DATA;
        end else if ((sz == 2'd3) && data2[7]) begin
          rec.code = RC_BAD_DATA;
        end else begin
          // Running status bookkeeping.
          if (!running_status_on_r) begin
            run = 1'b0;
          end else if (chan) begin
            if ((status_in[7:4] == HI_NOTE_OFF) && note_off_to_note_on_r) begin
              st_m = {HI_NOTE_ON, status_in[3:0]};
              d2_m = 8'h00;
            end
            run  = (st_m == prev);
            prev = st_m;
          end else if (run) begin
            due = 1'b1;
          end
          if (hdr) begin
            bb[n] = hbyte;
            n     = n + 1'b1;
          end
          skip = run && (timestamp == last_timestamp_r) && chan && !due;
          if (!skip) begin
            bb[n] = sbyte;
            n     = n + 1'b1;
          end
          if (due && chan) begin
            due = 1'b0;
          end
          if (!(run && chan)) begin
            bb[n] = st_m;
            n     = n + 1'b1;
          end
          if (sz >= 2'd2) begin
            bb[n] = data1;
            n     = n + 1'b1;
          end
          if (sz == 2'd3) begin
            bb[n] = d2_m;
            n     = n + 1'b1;
          end
          app     = 1'b1;
          msg_upd = 1'b1;
        end
      end
      KIND_SX_START: begin
        if (sysex_open_r) begin
          rec.code = RC_IN_SYSEX;
        end else begin
          if (hdr) begin
            bb[n] = hbyte;
            n     = n + 1'b1;
          end
          bb[n]    = sbyte;
          n        = n + 1'b1;
          bb[n]    = ST_SYSEX_START;
          n        = n + 1'b1;
          app      = 1'b1;
          sx_start = 1'b1;
        end
      end
      KIND_SX_DATA: begin
        if (!sysex_open_r) begin
          rec.code = RC_NOT_IN_SYSEX;
        end else if (data1[7]) begin
          rec.code = RC_BAD_DATA;
        end else begin
          if (hdr) begin
            bb[n] = hbyte;
            n     = n + 1'b1;
          end
          bb[n] = data1;
          n     = n + 1'b1;
          app   = 1'b1;
        end
      end
      KIND_SX_END: begin
        if (!sysex_open_r) begin
          rec.code = RC_NOT_IN_SYSEX;
        end else begin
          if (hdr) begin
            bb[n] = hbyte;
            n     = n + 1'b1;
          end
          bb[n]  = sbyte;
          n      = n + 1'b1;
          bb[n]  = ST_SYSEX_END;
          n      = n + 1'b1;
          app    = 1'b1;
          sx_end = 1'b1;
        end
      end
      KIND_PKT_RESET: begin
        byte_count_nxt     = '0;
        last_status_nxt    = '0;
        last_timestamp_nxt = '0;
        running_active_nxt = 1'b0;
        timestamp_due_nxt  = 1'b0;
      end
      default: ;
    endcase

    // All bytes fit in the packet, or none are appended.
    sum = {1'b0, byte_count_r} + SUM_W'(n);
    if (app) begin
      if (sum > limit) begin
        rec.code = RC_PACKET_FULL;
      end else begin
        rec.cnt        = n;
        rec.bytes      = bb;
        byte_count_nxt = sum[CNT_W-1:0];
        if (msg_upd) begin
          last_status_nxt    = prev;
          last_timestamp_nxt = timestamp;
          timestamp_due_nxt  = due;
          running_active_nxt = run;
        end
        if (sx_start) begin
          sysex_open_nxt     = 1'b1;
          running_active_nxt = 1'b0;
          last_status_nxt    = '0;
        end
        if (sx_end) begin
          sysex_open_nxt = 1'b0;
        end
      end
    end
  end

  // Packet state advances on each accepted beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r     <= '0;
      last_status_r    <= '0;
      last_timestamp_r <= '0;
      running_active_r <= 1'b0;
      timestamp_due_r  <= 1'b0;
      sysex_open_r     <= 1'b0;
    end else if (push) begin
      byte_count_r     <= byte_count_nxt;
      last_status_r    <= last_status_nxt;
      last_timestamp_r <= last_timestamp_nxt;
      running_active_r <= running_active_nxt;
      timestamp_due_r  <= timestamp_due_nxt;
      sysex_open_r     <= sysex_open_nxt;
    end
  end

endmodule

FILE: src/bmpb_queue.sv
// Short queue of classified item records between the front and the back.
// Depends on bmpb_pkg for the record type and depth.
module bmpb_queue import bmpb_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  rec_t    wr_rec,
  input  logic    pop,
  output rec_t    rd_rec,
  output q_stat_t stat
);

  rec_t              q_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r,  count_nxt;

  assign stat.full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign stat.empty = (count_r == '0);
  assign rd_rec     = q_r[rd_ptr_r];

  // Pointer and fill level updates; wrap at the depth.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Record storage.
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= wr_rec;
    end
  end

endmodule

FILE: src/bmpb_back.sv
// Back end: walks the record at the head of the queue and presents one result
// per beat from an output register. Depends on bmpb_pkg.
module bmpb_back import bmpb_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  rec_t       head,
  input  logic       head_valid,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       has_byte,
  output logic [2:0] result_code,
  output logic       last
);

  logic [NB_W-1:0] pos_r,  pos_nxt;
  logic            vld_r,  vld_nxt;
  logic [7:0]      byte_r, byte_nxt;
  logic            has_r,  has_nxt;
  logic [2:0]      code_r, code_nxt;
  logic            last_r, last_nxt;
  logic            load;

  assign out_valid   = vld_r;
  assign out_byte    = byte_r;
  assign has_byte    = has_r;
  assign result_code = code_r;
  assign last        = last_r;

  // A new result enters the output register when it is empty or being taken.
  assign load = head_valid && (!vld_r || out_ready);

  always_comb begin
    pos_nxt  = pos_r;
    byte_nxt = byte_r;
    has_nxt  = has_r;
    code_nxt = code_r;
    last_nxt = last_r;
    pop      = 1'b0;
    vld_nxt  = out_ready ? 1'b0 : vld_r;
    if (load) begin
      vld_nxt = 1'b1;
      if (head.cnt == '0) begin
        // Error, reset or ignored item: one result without a byte.
        byte_nxt = 8'h00;
        has_nxt  = 1'b0;
        code_nxt = head.code;
        last_nxt = 1'b1;
        pop      = 1'b1;
      end else begin
        byte_nxt = head.bytes[pos_r];
        has_nxt  = 1'b1;
        code_nxt = RC_OK;
        last_nxt = (pos_r + 1'b1 == head.cnt);
        if (last_nxt) begin
          pop     = 1'b1;
          pos_nxt = '0;
        end else begin
          pos_nxt = pos_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      vld_r <= 1'b0;
    end else begin
      pos_r <= pos_nxt;
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    has_r  <= has_nxt;
    code_r <= code_nxt;
    last_r <= last_nxt;
  end

endmodule
